@@ rtl/core/vcf_variant_type_classifier_macros.svh @@
// assertion macros for the variant type classifier
// expects clk_i and rst_ni in the scope of the including module
`ifndef VCF_VARIANT_TYPE_CLASSIFIER_MACROS_SVH
`define VCF_VARIANT_TYPE_CLASSIFIER_MACROS_SVH

// same-cycle implication, off during reset
`define VCF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vcf assertion failed");

// next-cycle implication, off during reset
`define VCF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vcf assertion failed");

`endif

@@ rtl/core/vcf_pkg.sv @@
// shared types and constants of the variant type classifier
// no dependencies
`default_nettype none

package vcf_pkg;

  // byte codes of the text stream
  localparam logic [7:0] BYTE_NEWLINE = 8'd10;
  localparam logic [7:0] BYTE_TAB     = 8'd9;
  localparam logic [7:0] BYTE_COMMA   = 8'd44;
  localparam logic [7:0] BYTE_HASH    = 8'd35;

  // field numbering
  localparam logic [2:0] REF_FIELD  = 3'd3;
  localparam logic [2:0] ALT_FIELD  = 3'd4;
  localparam logic [2:0] FIELD_MAX  = 3'd7;
  localparam logic [2:0] MIN_FIELDS = 3'd5;

  // threshold register
  localparam int unsigned THRESH_W        = 16;
  localparam logic [15:0] THRESHOLD_RESET = 16'd50;

  // reported total width
  localparam int unsigned TOTAL_W = 32;

  typedef enum logic [2:0] {
    KIND_HEADER = 3'd0,
    KIND_SNP    = 3'd1,
    KIND_INDEL  = 3'd2,
    KIND_SV     = 3'd3,
    KIND_SHORT  = 3'd4
  } line_kind_e;

  // verdict handed from the parser to the tally
  typedef struct packed {
    logic       fire;
    line_kind_e kind;
  } vcf_verdict_t;

endpackage

`default_nettype wire

@@ rtl/core/vcf_byte_if.sv @@
// byte request channel of the variant type classifier
// no dependencies
`default_nettype none

interface vcf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface

`default_nettype wire

@@ rtl/core/vcf_result_if.sv @@
// result request channel of the variant type classifier
// depends on vcf_pkg
`default_nettype none

interface vcf_result_if
  import vcf_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [2:0]         line_kind;
  logic [TOTAL_W-1:0] variant_total;
  logic [TOTAL_W-1:0] snp_total;
  logic [TOTAL_W-1:0] indel_total;
  logic [TOTAL_W-1:0] sv_total;

  modport source (
    output valid, output line_kind, output variant_total, output snp_total,
    output indel_total, output sv_total, input ready
  );
  modport sink (
    input valid, input line_kind, input variant_total, input snp_total,
    input indel_total, input sv_total, output ready
  );
endinterface

`default_nettype wire

@@ rtl/core/vcf_variant_type_classifier.sv @@
// Variant type classifier: one byte of variant-call text in per request, one verdict
// out per line. Byte requests arrive on byte_i, verdicts with running totals leave on
// result_o; both are valid/ready channels, a request moves when valid and ready are high.
// cfg_we_i/cfg_wdata_i write the length threshold above which an InDel counts as an SV;
// write it only while no line is in flight.
// Each byte is first held in an input register, then the line parser updates its field
// state from it; a newline loads the verdict into the result register.
// A newline's verdict shows on result_o once the result register has taken it.
// Throughput: one byte per cycle while no newline waits, set by the parser state update.
// When result_o stalls, ordinary bytes keep flowing; a newline waits in the input
// register until the result register is free, and byte_i.ready drops behind it.
// Reset clears the line state, the totals and both registers, and sets the threshold
// to 50; the block is ready for requests as soon as reset is released.
// depends on vcf_pkg, vcf_byte_if, vcf_result_if, vcf_line_parser, vcf_line_tally
`default_nettype none

`include "vcf_variant_type_classifier_macros.svh"

module vcf_variant_type_classifier
  import vcf_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 16,
  parameter int unsigned COUNT_BITS  = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [THRESH_W-1:0] cfg_wdata_i,
  vcf_byte_if.sink                 byte_i,
  vcf_result_if.source             result_o
);

  logic                in_valid_q, in_valid_d;
  logic [7:0]          byte_q, byte_d;
  logic [THRESH_W-1:0] threshold_q;
  logic                out_free, consume;
  vcf_verdict_t        verdict;

  // a newline may only move on when the result slot is free this cycle
  assign out_free = !result_o.valid || result_o.ready;
  assign consume  = in_valid_q && ((byte_q != BYTE_NEWLINE) || out_free);
  assign byte_i.ready = !in_valid_q || consume;

  // input register
  always_comb begin
    in_valid_d = in_valid_q;
    byte_d     = byte_q;
    if (byte_i.ready) begin
      in_valid_d = byte_i.valid;
      byte_d     = byte_i.text_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      threshold_q <= THRESHOLD_RESET;
    end else begin
      in_valid_q <= in_valid_d;
      if (cfg_we_i) begin
        threshold_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  vcf_line_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .consume_i  (consume),
    .byte_i     (byte_q),
    .threshold_i(threshold_q),
    .verdict_o  (verdict)
  );

  vcf_line_tally #(
    .COUNT_BITS(COUNT_BITS)
  ) u_tally (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .verdict_i(verdict),
    .result_o (result_o)
  );

  // a verdict never overwrites a result still waiting
  `VCF_ASSERT_NOW(a_verdict_slot_free, verdict.fire, out_free)
  // a held byte stays put while it cannot move on
  `VCF_ASSERT_NEXT(a_held_byte_stable, in_valid_q && !consume, $stable(byte_q) && in_valid_q)
  // a short line leaves the variant total alone
  `VCF_ASSERT_NEXT(a_short_no_count, verdict.fire && verdict.kind == KIND_SHORT,
                   $stable(result_o.variant_total))

endmodule

`default_nettype wire

@@ rtl/core/vcf_line_parser.sv @@
// per-line field parser: tracks field number and allele lengths, classifies on newline
// depends on vcf_pkg
`default_nettype none

module vcf_line_parser
  import vcf_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                consume_i,
  input  wire logic [7:0]          byte_i,
  input  wire logic [THRESH_W-1:0] threshold_i,
  output vcf_verdict_t             verdict_o
);

  localparam int unsigned CmpW = (LENGTH_BITS > THRESH_W) ? LENGTH_BITS : THRESH_W;
  localparam logic [LENGTH_BITS-1:0] LenOne = LENGTH_BITS'(1);

  logic [2:0]             field_number_q, field_number_d;
  logic                   field_nonempty_q, field_nonempty_d;
  logic                   line_nonempty_q, line_nonempty_d;
  logic                   header_line_q, header_line_d;
  logic [LENGTH_BITS-1:0] ref_len_q, ref_len_d;
  logic [LENGTH_BITS-1:0] allele_len_q, allele_len_d;
  logic [LENGTH_BITS-1:0] longest_q, longest_d;

  logic                   is_nl, is_tab, is_comma, header_eff;
  logic [2:0]             field_end;
  logic [LENGTH_BITS-1:0] longest_end;
  logic [CmpW-1:0]        ref_x, longest_x, thresh_x;
  line_kind_e             line_kind;

  assign is_nl      = (byte_i == BYTE_NEWLINE);
  assign is_tab     = (byte_i == BYTE_TAB);
  assign is_comma   = (byte_i == BYTE_COMMA);
  assign header_eff = header_line_q | (!line_nonempty_q && (byte_i == BYTE_HASH));

  // close the open field as the newline would, then classify
  always_comb begin
    field_end   = field_number_q;
    longest_end = longest_q;
    if (field_nonempty_q) begin
      if (field_number_q == ALT_FIELD && allele_len_q > longest_q) begin
        longest_end = allele_len_q;
      end
      if (field_number_q < FIELD_MAX) begin
        field_end = field_number_q + 3'd1;
      end
    end
    ref_x     = CmpW'(ref_len_q);
    longest_x = CmpW'(longest_end);
    thresh_x  = CmpW'(threshold_i);
    if (!line_nonempty_q || header_line_q) begin
      line_kind = KIND_HEADER;
    end else if (field_end < MIN_FIELDS) begin
      line_kind = KIND_SHORT;
    end else if (ref_len_q == LenOne && longest_end <= LenOne) begin
      line_kind = KIND_SNP;
    end else if (ref_x > thresh_x || longest_x > thresh_x) begin
      line_kind = KIND_SV;
    end else begin
      line_kind = KIND_INDEL;
    end
  end

  // next line state for the byte taken this cycle
  always_comb begin
    field_number_d   = field_number_q;
    field_nonempty_d = field_nonempty_q;
    line_nonempty_d  = line_nonempty_q;
    header_line_d    = header_line_q;
    ref_len_d        = ref_len_q;
    allele_len_d     = allele_len_q;
    longest_d        = longest_q;
    verdict_o        = '{fire: 1'b0, kind: KIND_HEADER};
    if (consume_i) begin
      if (!is_nl) begin
        line_nonempty_d = 1'b1;
        header_line_d   = header_eff;
        if (!header_eff) begin
          if (is_tab) begin
            if (field_nonempty_q) begin
              if (field_number_q == ALT_FIELD && allele_len_q > longest_q) begin
                longest_d = allele_len_q;
              end
              if (field_number_q < FIELD_MAX) begin
                field_number_d = field_number_q + 3'd1;
              end
            end
            field_nonempty_d = 1'b0;
            allele_len_d     = '0;
          end else begin
            field_nonempty_d = 1'b1;
            if (field_number_q == REF_FIELD) begin
              if (ref_len_q != '1) begin
                ref_len_d = ref_len_q + LenOne;
              end
            end else if (field_number_q == ALT_FIELD) begin
              if (is_comma) begin
                if (allele_len_q > longest_q) begin
                  longest_d = allele_len_q;
                end
                allele_len_d = '0;
              end else if (allele_len_q != '1) begin
                allele_len_d = allele_len_q + LenOne;
              end
            end
          end
        end
      end else begin
        verdict_o        = '{fire: 1'b1, kind: line_kind};
        field_number_d   = '0;
        field_nonempty_d = 1'b0;
        line_nonempty_d  = 1'b0;
        header_line_d    = 1'b0;
        ref_len_d        = '0;
        allele_len_d     = '0;
        longest_d        = '0;
      end
    end
  end

  // line state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_number_q   <= '0;
      field_nonempty_q <= 1'b0;
      line_nonempty_q  <= 1'b0;
      header_line_q    <= 1'b0;
      ref_len_q        <= '0;
      allele_len_q     <= '0;
      longest_q        <= '0;
    end else begin
      field_number_q   <= field_number_d;
      field_nonempty_q <= field_nonempty_d;
      line_nonempty_q  <= line_nonempty_d;
      header_line_q    <= header_line_d;
      ref_len_q        <= ref_len_d;
      allele_len_q     <= allele_len_d;
      longest_q        <= longest_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/vcf_line_tally.sv @@
// saturating line totals and the result register
// depends on vcf_pkg and vcf_result_if
`default_nettype none

module vcf_line_tally
  import vcf_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire vcf_verdict_t  verdict_i,
  vcf_result_if.source       result_o
);

  localparam logic [COUNT_BITS-1:0] CntOne = COUNT_BITS'(1);

  logic [COUNT_BITS-1:0] variant_cnt_q, variant_cnt_d;
  logic [COUNT_BITS-1:0] snp_cnt_q, snp_cnt_d;
  logic [COUNT_BITS-1:0] indel_cnt_q, indel_cnt_d;
  logic [COUNT_BITS-1:0] sv_cnt_q, sv_cnt_d;
  logic                  valid_q, valid_d;
  line_kind_e            kind_q, kind_d;

  logic [COUNT_BITS+TOTAL_W-1:0] variant_x, snp_x, indel_x, sv_x;
  logic                          is_variant;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == '1) ? v : v + CntOne;
  endfunction

  // counter updates on a verdict
  always_comb begin
    variant_cnt_d = variant_cnt_q;
    snp_cnt_d     = snp_cnt_q;
    indel_cnt_d   = indel_cnt_q;
    sv_cnt_d      = sv_cnt_q;
    is_variant    = 1'b0;
    case (verdict_i.kind)
      KIND_SNP: begin
        is_variant = 1'b1;
        snp_cnt_d  = sat_inc(snp_cnt_q);
      end
      KIND_INDEL: begin
        is_variant  = 1'b1;
        indel_cnt_d = sat_inc(indel_cnt_q);
      end
      KIND_SV: begin
        is_variant = 1'b1;
        sv_cnt_d   = sat_inc(sv_cnt_q);
      end
      default: begin
        is_variant = 1'b0;
      end
    endcase
    if (is_variant) begin
      variant_cnt_d = sat_inc(variant_cnt_q);
    end
    if (!verdict_i.fire) begin
      variant_cnt_d = variant_cnt_q;
      snp_cnt_d     = snp_cnt_q;
      indel_cnt_d   = indel_cnt_q;
      sv_cnt_d      = sv_cnt_q;
    end
  end

  // result slot: loaded by a verdict, emptied when taken
  always_comb begin
    valid_d = valid_q;
    kind_d  = kind_q;
    if (verdict_i.fire) begin
      valid_d = 1'b1;
      kind_d  = verdict_i.kind;
    end else if (result_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      variant_cnt_q <= '0;
      snp_cnt_q     <= '0;
      indel_cnt_q   <= '0;
      sv_cnt_q      <= '0;
      valid_q       <= 1'b0;
      kind_q        <= KIND_HEADER;
    end else begin
      variant_cnt_q <= variant_cnt_d;
      snp_cnt_q     <= snp_cnt_d;
      indel_cnt_q   <= indel_cnt_d;
      sv_cnt_q      <= sv_cnt_d;
      valid_q       <= valid_d;
      kind_q        <= kind_d;
    end
  end

  // totals report the low bits of the counters
  assign variant_x = {{TOTAL_W{1'b0}}, variant_cnt_q};
  assign snp_x     = {{TOTAL_W{1'b0}}, snp_cnt_q};
  assign indel_x   = {{TOTAL_W{1'b0}}, indel_cnt_q};
  assign sv_x      = {{TOTAL_W{1'b0}}, sv_cnt_q};

  assign result_o.valid         = valid_q;
  assign result_o.line_kind     = kind_q;
  assign result_o.variant_total = variant_x[TOTAL_W-1:0];
  assign result_o.snp_total     = snp_x[TOTAL_W-1:0];
  assign result_o.indel_total   = indel_x[TOTAL_W-1:0];
  assign result_o.sv_total      = sv_x[TOTAL_W-1:0];

endmodule

`default_nettype wire
